>>> hdl/rsd_pkg.sv
// ---------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants for the RRIP/SHiP dueling replacement block.
// ---------------------------------------------------------------------------
package rsd_pkg;

   localparam int SET_W = 11;
   localparam int WAY_W = 4;
   localparam int PC_W = 12;
   localparam int STAT_W = 21;
   localparam int THR_W = 3;
   localparam int CSR_ADDR_W = 3;

   localparam logic [1:0] RRPV_MAX = 2'd3;
   localparam logic [1:0] RRPV_LONG = 2'd2;
   localparam logic [2:0] CTR_MAX = 3'd7;
   localparam logic [2:0] CTR_INIT = 3'd4;
   localparam logic [STAT_W-1:0] STAT_MAX = {STAT_W{1'b1}};

   localparam logic CMD_VICTIM = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_SAMPLES = 3'd4;

   localparam logic [THR_W-1:0] THR_RESET = 3'd4;
   localparam logic [STAT_W-1:0] MIN_SAMPLES_RESET = 21'd100;

   // One classified command, as passed from the front to the back.
   typedef struct packed {
      logic             command;
      logic [SET_W-1:0] set_index;
      logic [WAY_W-1:0] way_index;
      logic [PC_W-1:0]  pc_low;
      logic             was_hit;
      logic             ship_lead;
   } cmd_type;

endpackage

>>> hdl/rsd_if.sv
// ---------------------------------------------------------------------------
// rsd_req_if / rsd_rsp_if
// Valid/ready channels carrying requests and results.
// ---------------------------------------------------------------------------
interface rsd_req_if;
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [rsd_pkg::SET_W-1:0]  set_index;
   logic [rsd_pkg::WAY_W-1:0]  way_index;
   logic [rsd_pkg::PC_W-1:0]   pc_low;
   logic                       was_hit;
   modport source (output valid, command, set_index, way_index, pc_low, was_hit,
                   input ready);
   modport sink (input valid, command, set_index, way_index, pc_low, was_hit,
                 output ready);
endinterface

interface rsd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rsd_pkg::WAY_W-1:0]  victim_way;
   logic                       follower_mode;
   modport source (output valid, victim_way, follower_mode, input ready);
   modport sink (input valid, victim_way, follower_mode, output ready);
endinterface

>>> hdl/rsd_front.sv
// ---------------------------------------------------------------------------
// rsd_front
// Accepts requests, classifies leader sets, and queues them for the back.
// ---------------------------------------------------------------------------
module rsd_front #(
   parameter int DUEL_GROUP = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   rsd_req_if.sink              req,
   output logic                 q_valid,
   input  logic                 q_pop,
   output rsd_pkg::cmd_type     q_data
);

   localparam int DG_W = $clog2(DUEL_GROUP);

   // Two-entry queue.
   rsd_pkg::cmd_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   rsd_pkg::cmd_type cls;
   logic             push;
   logic [31:0]      set_wide;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready;
   assign set_wide = 32'(req.set_index);

   // Leader classification: upper half of each duel group runs SHiP.
   always_comb begin
      cls.command = req.command;
      cls.set_index = req.set_index;
      cls.way_index = req.way_index;
      cls.pc_low = req.pc_low;
      cls.was_hit = req.was_hit;
      cls.ship_lead = set_wide[DG_W-1];
   end

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cls;
      end
   end

   assign q_valid = (cnt_ff != 2'd0);
   assign q_data = mem_ff[rd_ptr_ff];

endmodule

>>> hdl/rsd_back.sv
// ---------------------------------------------------------------------------
// rsd_back
// Executes victim and update commands against the RRPV and signature
// memories, keeps the duel statistics and drives the result register.
// ---------------------------------------------------------------------------
module rsd_back #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16,
   parameter int SIG_ENTRIES = 4096,
   parameter int EPOCH_LOG2 = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_pop,
   input  rsd_pkg::cmd_type                 q_data,
   input  logic [rsd_pkg::THR_W-1:0]        thr,
   input  logic [rsd_pkg::STAT_W-1:0]       min_samples,
   rsd_rsp_if.source                        rsp
);

   localparam int SI_W = $clog2(NUM_SETS);
   localparam int WI_W = $clog2(NUM_WAYS);
   localparam int GI_W = $clog2(SIG_ENTRIES);
   localparam int CLR_W = ((SI_W > GI_W) ? SI_W : GI_W) + 1;
   localparam int ROW_W = 2 * NUM_WAYS;
   localparam int PROD_W = 2 * rsd_pkg::STAT_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_READ = 3'd2;
   localparam logic [2:0] ST_EXEC = 3'd3;
   localparam logic [2:0] ST_MUL = 3'd4;
   localparam logic [2:0] ST_CMP = 3'd5;
   localparam logic [2:0] ST_OUT = 3'd6;

   // Memories: one wide row per set, one counter per signature.
   logic [ROW_W-1:0] row_mem [NUM_SETS];
   logic [2:0]       sig_mem [SIG_ENTRIES];

   logic [2:0]       state_ff, state_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   rsd_pkg::cmd_type cmd_ff;
   logic [ROW_W-1:0] row_rd_ff;
   logic [2:0]       sig_rd_ff;
   logic [EPOCH_LOG2-1:0] epoch_ff;
   logic [rsd_pkg::STAT_W-1:0] sr_hit_ff, sr_acc_ff, sh_hit_ff, sh_acc_ff;
   logic [PROD_W-1:0] lhs_ff, rhs_ff;
   logic             mode_ff;
   logic             rsp_valid_ff;
   logic [rsd_pkg::WAY_W-1:0] victim_ff;

   logic [SI_W-1:0]  set_a;
   logic [GI_W-1:0]  sig_a;
   logic [SI_W-1:0]  row_wa;
   logic [ROW_W-1:0] row_wd;
   logic             row_we;
   logic [2:0]       sig_wd;
   logic             sig_we;
   logic [1:0]       top;
   logic [WI_W-1:0]  best;
   logic [ROW_W-1:0] aged;
   logic [ROW_W-1:0] upd_row;
   logic [1:0]       ins;
   logic             way_ok;
   logic             epoch_wrap;
   logic             samples_ok;

   assign set_a = SI_W'(q_data.set_index);
   assign sig_a = GI_W'(q_data.pc_low);
   assign q_pop = (state_ff == ST_IDLE) && q_valid;
   assign way_ok = (32'(cmd_ff.way_index) < NUM_WAYS);
   assign epoch_wrap = (epoch_ff == {EPOCH_LOG2{1'b1}});
   assign samples_ok = (sr_acc_ff >= min_samples) && (sh_acc_ff >= min_samples);

   // Highest RRPV in the row, first way holding it, and the aged row.
   always_comb begin
      top = 2'd0;
      best = '0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (row_rd_ff[2*w +: 2] > top) begin
            top = row_rd_ff[2*w +: 2];
            best = WI_W'(w);
         end
      end
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[2*w +: 2] = row_rd_ff[2*w +: 2] + (rsd_pkg::RRPV_MAX - top);
      end
   end

   // Insertion value and the row with the accessed way rewritten.
   always_comb begin
      if (cmd_ff.was_hit) begin
         ins = 2'd0;
      end else if (cmd_ff.ship_lead && (sig_rd_ff < thr)) begin
         ins = rsd_pkg::RRPV_MAX;
      end else begin
         ins = rsd_pkg::RRPV_LONG;
      end
      upd_row = row_rd_ff;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (way_ok && (32'(cmd_ff.way_index) == w)) begin
            upd_row[2*w +: 2] = ins;
         end
      end
   end

   // Memory write selection.
   always_comb begin
      row_we = 1'b0;
      row_wa = SI_W'(cmd_ff.set_index);
      row_wd = upd_row;
      sig_we = 1'b0;
      sig_wd = sig_rd_ff;
      if (state_ff == ST_CLEAR) begin
         row_we = 1'b1;
         row_wa = clr_ff[SI_W-1:0];
         row_wd = {NUM_WAYS{rsd_pkg::RRPV_MAX}};
         sig_we = 1'b1;
         sig_wd = rsd_pkg::CTR_INIT;
      end else if (state_ff == ST_EXEC) begin
         if (cmd_ff.command == rsd_pkg::CMD_VICTIM) begin
            row_we = (top != rsd_pkg::RRPV_MAX);
            row_wd = aged;
         end else begin
            row_we = way_ok;
            row_wd = upd_row;
            sig_we = cmd_ff.ship_lead;
            if (cmd_ff.was_hit) begin
               sig_wd = (sig_rd_ff < rsd_pkg::CTR_MAX) ? sig_rd_ff + 3'd1 : sig_rd_ff;
            end else begin
               sig_wd = (sig_rd_ff != 3'd0) ? sig_rd_ff - 3'd1 : sig_rd_ff;
            end
         end
      end
   end

   // Memory ports: one write and one registered read each.
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_wa] <= row_wd;
      end
      if (q_pop) begin
         row_rd_ff <= row_mem[set_a];
      end
   end

   always_ff @(posedge clock) begin
      if (sig_we) begin
         if (state_ff == ST_CLEAR) begin
            sig_mem[clr_ff[GI_W-1:0]] <= sig_wd;
         end else begin
            sig_mem[GI_W'(cmd_ff.pc_low)] <= sig_wd;
         end
      end
      if (q_pop) begin
         sig_rd_ff <= sig_mem[sig_a];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if ((32'(clr_ff) + 1 >= NUM_SETS) && (32'(clr_ff) + 1 >= SIG_ENTRIES)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_pop) begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_EXEC;
         ST_EXEC: begin
            if ((cmd_ff.command == rsd_pkg::CMD_UPDATE) && epoch_wrap) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_MUL: state_in = ST_CMP;
         ST_CMP: state_in = ST_OUT;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff <= (state_ff == ST_CLEAR) ? clr_in : clr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff <= q_data;
      end
      if (state_ff == ST_EXEC) begin
         victim_ff <= (cmd_ff.command == rsd_pkg::CMD_VICTIM) ?
                      rsd_pkg::WAY_W'(best) : '0;
      end
      if (state_ff == ST_MUL) begin
         lhs_ff <= PROD_W'(sh_hit_ff) * PROD_W'(sr_acc_ff);
         rhs_ff <= PROD_W'(sr_hit_ff) * PROD_W'(sh_acc_ff);
      end
   end

   // Duel statistics, epoch counter and mode.
   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= '0;
         sr_hit_ff <= '0;
         sr_acc_ff <= '0;
         sh_hit_ff <= '0;
         sh_acc_ff <= '0;
         mode_ff <= 1'b0;
      end else if ((state_ff == ST_EXEC) && (cmd_ff.command == rsd_pkg::CMD_UPDATE)) begin
         epoch_ff <= epoch_ff + 1'b1;
         if (cmd_ff.ship_lead) begin
            if (sh_acc_ff != rsd_pkg::STAT_MAX) sh_acc_ff <= sh_acc_ff + 1'b1;
            if (cmd_ff.was_hit && (sh_hit_ff != rsd_pkg::STAT_MAX)) begin
               sh_hit_ff <= sh_hit_ff + 1'b1;
            end
         end else begin
            if (sr_acc_ff != rsd_pkg::STAT_MAX) sr_acc_ff <= sr_acc_ff + 1'b1;
            if (cmd_ff.was_hit && (sr_hit_ff != rsd_pkg::STAT_MAX)) begin
               sr_hit_ff <= sr_hit_ff + 1'b1;
            end
         end
      end else if (state_ff == ST_CMP) begin
         if (samples_ok) begin
            mode_ff <= (lhs_ff > rhs_ff);
         end
         sr_hit_ff <= '0;
         sr_acc_ff <= '0;
         sh_hit_ff <= '0;
         sh_acc_ff <= '0;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp.ready)) begin
         rsp.victim_way <= victim_ff;
         rsp.follower_mode <= mode_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;

endmodule

>>> hdl/rrip_ship_dueling_replacement.sv
// ---------------------------------------------------------------------------
// rrip_ship_dueling_replacement
// LLC replacement with SRRIP/SHiP set dueling and per-signature counters.
// ---------------------------------------------------------------------------
// A command is popped in IDLE, its RRPV row and signature counter read into
// registers; it then passes READ, EXEC (read-modify-write), MUL and CMP at an
// epoch end, and OUT; no new command is popped before the back is in IDLE.
// Reset: synchronous; a clearing pass over max(NUM_SETS, SIG_ENTRIES) entries
// (4096 by default) then runs before the first request is executed.
module rrip_ship_dueling_replacement #(
   parameter int NUM_SETS = 2048,
   parameter int NUM_WAYS = 16,
   parameter int SIG_ENTRIES = 4096,
   parameter int DUEL_GROUP = 64,
   parameter int EPOCH_LOG2 = 20
) (
   input  logic        clock,
   input  logic        reset,
   rsd_req_if.sink     req,
   rsd_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [rsd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                       q_valid;
   logic                       q_pop;
   rsd_pkg::cmd_type           q_data;
   logic [rsd_pkg::THR_W-1:0]  thr_ff;
   logic [rsd_pkg::STAT_W-1:0] min_ff;
   logic                       wr;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= rsd_pkg::THR_RESET;
         min_ff <= rsd_pkg::MIN_SAMPLES_RESET;
      end else if (wr) begin
         if (csr_paddr == rsd_pkg::CSR_THRESHOLD) begin
            thr_ff <= csr_pwdata[rsd_pkg::THR_W-1:0];
         end else if (csr_paddr == rsd_pkg::CSR_MIN_SAMPLES) begin
            min_ff <= csr_pwdata[rsd_pkg::STAT_W-1:0];
         end
      end
   end

   always_comb begin
      case (csr_paddr)
         rsd_pkg::CSR_THRESHOLD: csr_prdata = 32'(thr_ff);
         rsd_pkg::CSR_MIN_SAMPLES: csr_prdata = 32'(min_ff);
         default: csr_prdata = '0;
      endcase
   end

   rsd_front #(.DUEL_GROUP(DUEL_GROUP)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
   );

   rsd_back #(
      .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
      .SIG_ENTRIES(SIG_ENTRIES), .EPOCH_LOG2(EPOCH_LOG2)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(q_data), .thr(thr_ff), .min_samples(min_ff), .rsp(rsp)
   );

   // A queue pop only happens when the queue holds an entry.
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");

   // The back never takes two commands on consecutive cycles.
   a_pop_next: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !q_pop) else $error("back popped twice in a row");

endmodule
